### rtl/core/frame_auto_exposure_core_macros.svh
// Assertion helpers for the core top file.
`ifndef FRAME_AUTO_EXPOSURE_CORE_MACROS_SVH
`define FRAME_AUTO_EXPOSURE_CORE_MACROS_SVH

// Check cons in the same cycle as ante.
`define FAE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define FAE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/fae_pkg.sv
package fae_pkg;

   localparam int PIX_W      = 8;
   localparam int SUM_W      = 25;
   localparam int EXP_W      = 20;
   localparam int GAIN_W     = 4;
   localparam int GEP_W      = GAIN_W + EXP_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AE_ENABLE    = 3'd0,
      CSR_TARGET_SUM   = 3'd1,
      CSR_INNER_LOW    = 3'd2,
      CSR_INNER_HIGH   = 3'd3,
      CSR_OUTER_LOW    = 3'd4,
      CSR_OUTER_HIGH   = 3'd5,
      CSR_MIN_EXPOSURE = 3'd6,
      CSR_MAX_EXPOSURE = 3'd7
   } csr_index_type;

   localparam logic [GAIN_W-1:0] GAIN_X1 = 4'd1;
   localparam logic [GAIN_W-1:0] GAIN_X2 = 4'd2;
   localparam logic [GAIN_W-1:0] GAIN_X4 = 4'd4;
   localparam logic [GAIN_W-1:0] GAIN_X8 = 4'd8;

   localparam logic [SUM_W-1:0] TARGET_SUM_RESET   = 25'd9753600;
   localparam logic [SUM_W-1:0] INNER_LOW_RESET    = 25'd9139200;
   localparam logic [SUM_W-1:0] INNER_HIGH_RESET   = 25'd10368000;
   localparam logic [SUM_W-1:0] OUTER_LOW_RESET    = 25'd8524800;
   localparam logic [SUM_W-1:0] OUTER_HIGH_RESET   = 25'd10982400;
   localparam logic [EXP_W-1:0] MIN_EXPOSURE_RESET = 20'd20;
   localparam logic [EXP_W-1:0] MAX_EXPOSURE_RESET = 20'd19140;
   localparam logic [EXP_W-1:0] EXPOSURE_RESET     = 20'd19140;
   localparam logic [GAIN_W-1:0] GAIN_RESET        = GAIN_X2;

   typedef struct packed {
      logic             ae_enable;
      logic [SUM_W-1:0] target_sum;
      logic [SUM_W-1:0] inner_low;
      logic [SUM_W-1:0] inner_high;
      logic [SUM_W-1:0] outer_low;
      logic [SUM_W-1:0] outer_high;
      logic [EXP_W-1:0] min_exposure;
      logic [EXP_W-1:0] max_exposure;
   } cfg_type;

   typedef struct packed {
      logic take_pixel;
      logic gep;
      logic mul;
      logic div_step;
      logic round_e1;
      logic pick_gain;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic go_compute;
      logic div_last;
   } status_type;

endpackage

### rtl/core/frame_auto_exposure_core.sv
// Frame auto exposure core.
// Request channel (req_valid/req_ready) carries one grayscale pixel per transfer;
// req_end_of_frame marks the last pixel of a frame. Pixels inside a frame are
// taken one per cycle and only summed; they produce no response.
// The response channel (rsp_valid/rsp_ready) carries one item per frame: exposure,
// gain, lock flag, an adjusted flag and the frame luma sum.
// rsp_valid rises in the cycle after the end-of-frame transfer when AE is off, the
// loop is locked or the frame sum is zero; otherwise it follows a computation in
// steps: product, multiply, a bit-serial divider that retires one quotient bit per cycle
// over the 49+FRAC_BITS bit numerator, then rounding, gain pick and a final step.
// During that computation req_ready is low. While a response waits for rsp_ready,
// pixels of the next frame are still taken; only its end-of-frame pixel is held.
// Configuration: csr_wr_en writes csr_wdata to register csr_index;
// write only while the core is idle.
// Reset (synchronous, active high) clears the running sum and the lock, loads
// exposure 19140 us and gain 2, and restores register defaults.
`include "frame_auto_exposure_core_macros.svh"

module frame_auto_exposure_core #(
   parameter int FRAC_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // pixel request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fae_pkg::PIX_W-1:0]        req_pixel,
   input  logic                             req_end_of_frame,
   // per-frame response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fae_pkg::EXP_W-1:0]        rsp_exposure_time,
   output logic [fae_pkg::GAIN_W-1:0]       rsp_gain_factor,
   output logic                             rsp_converged,
   output logic                             rsp_adjusted,
   output logic [fae_pkg::SUM_W-1:0]        rsp_luma_sum,
   // register write port
   input  logic                             csr_wr_en,
   input  logic [fae_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fae_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   fae_pkg::cfg_type    cfg;
   fae_pkg::cmd_type    cmd;
   fae_pkg::status_type status;

   // Hold the configuration registers.
   fae_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequence the frame-end computation and own both handshakes.
   fae_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_end_of_frame (req_end_of_frame),
      .req_ready        (req_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .status           (status),
      .cmd              (cmd)
   );

   // Accumulate, lock, multiply, divide, round and clamp.
   fae_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .req_pixel         (req_pixel),
      .req_end_of_frame  (req_end_of_frame),
      .status            (status),
      .rsp_exposure_time (rsp_exposure_time),
      .rsp_gain_factor   (rsp_gain_factor),
      .rsp_converged     (rsp_converged),
      .rsp_adjusted      (rsp_adjusted),
      .rsp_luma_sum      (rsp_luma_sum)
   );

   // A frame end must never overwrite a response still waiting.
   `FAE_ASSERT_NOW(a_eof_blocked, clock, reset, req_valid && req_ready && req_end_of_frame, !rsp_valid, "frame end taken while response pending")
   // Gain is always one of 1, 2, 4 or 8.
   `FAE_ASSERT_NOW(a_gain_onehot, clock, reset, rsp_valid, $onehot(rsp_gain_factor), "gain not a power of two")
   // A locked frame is never recomputed.
   `FAE_ASSERT_NOW(a_lock_no_adjust, clock, reset, rsp_valid && rsp_converged, !rsp_adjusted, "adjusted while locked")
   // The final compute step raises the response next cycle.
   `FAE_ASSERT_NEXT(a_finish_valid, clock, reset, cmd.finish, rsp_valid, "no response after compute")

endmodule

### rtl/core/fae_csr.sv
module fae_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [fae_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fae_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output fae_pkg::cfg_type                 cfg
);

   fae_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ae_enable    <= 1'b1;
         cfg_ff.target_sum   <= fae_pkg::TARGET_SUM_RESET;
         cfg_ff.inner_low    <= fae_pkg::INNER_LOW_RESET;
         cfg_ff.inner_high   <= fae_pkg::INNER_HIGH_RESET;
         cfg_ff.outer_low    <= fae_pkg::OUTER_LOW_RESET;
         cfg_ff.outer_high   <= fae_pkg::OUTER_HIGH_RESET;
         cfg_ff.min_exposure <= fae_pkg::MIN_EXPOSURE_RESET;
         cfg_ff.max_exposure <= fae_pkg::MAX_EXPOSURE_RESET;
      end else if (csr_wr_en) begin
         unique case (fae_pkg::csr_index_type'(csr_index))
            fae_pkg::CSR_AE_ENABLE:    cfg_ff.ae_enable    <= csr_wdata[0];
            fae_pkg::CSR_TARGET_SUM:   cfg_ff.target_sum   <= csr_wdata[fae_pkg::SUM_W-1:0];
            fae_pkg::CSR_INNER_LOW:    cfg_ff.inner_low    <= csr_wdata[fae_pkg::SUM_W-1:0];
            fae_pkg::CSR_INNER_HIGH:   cfg_ff.inner_high   <= csr_wdata[fae_pkg::SUM_W-1:0];
            fae_pkg::CSR_OUTER_LOW:    cfg_ff.outer_low    <= csr_wdata[fae_pkg::SUM_W-1:0];
            fae_pkg::CSR_OUTER_HIGH:   cfg_ff.outer_high   <= csr_wdata[fae_pkg::SUM_W-1:0];
            fae_pkg::CSR_MIN_EXPOSURE: cfg_ff.min_exposure <= csr_wdata[fae_pkg::EXP_W-1:0];
            fae_pkg::CSR_MAX_EXPOSURE: cfg_ff.max_exposure <= csr_wdata[fae_pkg::EXP_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/fae_ctrl.sv
module fae_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_end_of_frame,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  fae_pkg::status_type   status,
   output fae_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GEP,
      ST_MUL,
      ST_DIV,
      ST_ROUND,
      ST_GAIN,
      ST_FINAL
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      take;

   // Hold back a frame end while the previous result still waits.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || !req_end_of_frame);
   assign take      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.take_pixel = take;
      cmd.gep        = (state_ff == ST_GEP);
      cmd.mul        = (state_ff == ST_MUL);
      cmd.div_step   = (state_ff == ST_DIV);
      cmd.round_e1   = (state_ff == ST_ROUND);
      cmd.pick_gain  = (state_ff == ST_GAIN);
      cmd.finish     = (state_ff == ST_FINAL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (take && req_end_of_frame) begin
                  if (status.go_compute) begin
                     state_ff <= ST_GEP;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            ST_GEP:   state_ff <= ST_MUL;
            ST_MUL:   state_ff <= ST_DIV;
            ST_DIV: begin
               if (status.div_last) begin
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: state_ff <= ST_GAIN;
            ST_GAIN:  state_ff <= ST_FINAL;
            ST_FINAL: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### rtl/core/fae_dpath.sv
module fae_dpath #(
   parameter int FRAC_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  fae_pkg::cfg_type               cfg,
   input  fae_pkg::cmd_type               cmd,
   input  logic [fae_pkg::PIX_W-1:0]      req_pixel,
   input  logic                           req_end_of_frame,
   output fae_pkg::status_type            status,
   output logic [fae_pkg::EXP_W-1:0]      rsp_exposure_time,
   output logic [fae_pkg::GAIN_W-1:0]     rsp_gain_factor,
   output logic                           rsp_converged,
   output logic                           rsp_adjusted,
   output logic [fae_pkg::SUM_W-1:0]      rsp_luma_sum
);

   localparam int SUM_W  = fae_pkg::SUM_W;
   localparam int EXP_W  = fae_pkg::EXP_W;
   localparam int GEP_W  = fae_pkg::GEP_W;
   localparam int PROD_W = GEP_W + SUM_W;
   localparam int NUM_W  = PROD_W + FRAC_BITS;
   localparam int RND_W  = NUM_W - FRAC_BITS + 1;
   localparam int CNT_W  = $clog2(NUM_W);

   logic [SUM_W-1:0]          sum_ff;
   logic                      lock_ff;
   logic [EXP_W-1:0]          exp_ff;
   logic [fae_pkg::GAIN_W-1:0] gain_ff;
   logic [SUM_W-1:0]          fsum_ff;
   logic                      adj_ff;
   logic [GEP_W-1:0]          gep_ff;
   logic [NUM_W-1:0]          num_ff;
   logic [SUM_W-1:0]          rem_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [EXP_W-1:0]          e1_ff;
   logic [1:0]                lg_ff;

   logic [SUM_W:0]   sum_wide;
   logic [SUM_W-1:0] fsum;
   logic             lock_next;
   logic             recompute;
   logic [SUM_W:0]   trial;
   logic             fits;
   logic [SUM_W:0]   diff;
   logic [RND_W-1:0] rnd1;
   logic [RND_W-1:0] rnd2;
   logic [NUM_W-1:0] unit1;
   logic [NUM_W-1:0] unit2;
   logic [NUM_W-1:0] unit4;

   function automatic logic [EXP_W-1:0] clamp_exp(input logic [RND_W-1:0] v,
                                                  input logic [EXP_W-1:0] lo,
                                                  input logic [EXP_W-1:0] hi);
      logic [RND_W-1:0] r;
      r = v;
      if (r < RND_W'(lo)) r = RND_W'(lo);
      if (r > RND_W'(hi)) r = RND_W'(hi);
      return r[EXP_W-1:0];
   endfunction

   // Saturate the running sum at the field maximum.
   assign sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(req_pixel);
   assign fsum     = sum_wide[SUM_W] ? fae_pkg::SUM_MAX : sum_wide[SUM_W-1:0];

   always_comb begin
      if (cfg.inner_low <= fsum && fsum <= cfg.inner_high) begin
         lock_next = 1'b1;
      end else if (fsum > cfg.outer_high || fsum < cfg.outer_low) begin
         lock_next = 1'b0;
      end else begin
         lock_next = lock_ff;
      end
   end

   assign recompute         = cfg.ae_enable && !lock_next;
   assign status.go_compute = req_end_of_frame && recompute && (fsum != '0);
   assign status.div_last   = (cnt_ff == CNT_W'(NUM_W - 1));

   // One restoring division step: shift in the next numerator bit.
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign fits  = (trial >= {1'b0, fsum_ff});
   assign diff  = trial - {1'b0, fsum_ff};

   assign rnd1  = RND_W'(num_ff >> FRAC_BITS) + RND_W'(num_ff[FRAC_BITS-1]);
   assign unit1 = NUM_W'({e1_ff, {FRAC_BITS{1'b0}}});
   assign unit2 = unit1 << 1;
   assign unit4 = unit1 << 2;

   always_comb begin
      unique case (lg_ff)
         2'd0: rnd2 = RND_W'(num_ff >> FRAC_BITS)       + RND_W'(num_ff[FRAC_BITS-1]);
         2'd1: rnd2 = RND_W'(num_ff >> (FRAC_BITS + 1)) + RND_W'(num_ff[FRAC_BITS]);
         2'd2: rnd2 = RND_W'(num_ff >> (FRAC_BITS + 2)) + RND_W'(num_ff[FRAC_BITS+1]);
         2'd3: rnd2 = RND_W'(num_ff >> (FRAC_BITS + 3)) + RND_W'(num_ff[FRAC_BITS+2]);
         default: rnd2 = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         lock_ff <= 1'b0;
         exp_ff  <= fae_pkg::EXPOSURE_RESET;
         gain_ff <= fae_pkg::GAIN_RESET;
      end else begin
         if (cmd.take_pixel) begin
            if (req_end_of_frame) begin
               sum_ff <= '0;
               if (cfg.ae_enable) begin
                  lock_ff <= lock_next;
               end
               if (recompute && fsum == '0) begin
                  gain_ff <= fae_pkg::GAIN_X8;
                  exp_ff  <= cfg.max_exposure;
               end
            end else begin
               sum_ff <= fsum;
            end
         end
         if (cmd.finish) begin
            unique case (lg_ff)
               2'd0: gain_ff <= fae_pkg::GAIN_X1;
               2'd1: gain_ff <= fae_pkg::GAIN_X2;
               2'd2: gain_ff <= fae_pkg::GAIN_X4;
               2'd3: gain_ff <= fae_pkg::GAIN_X8;
               default: gain_ff <= fae_pkg::GAIN_X8;
            endcase
            exp_ff <= clamp_exp(rnd2, cfg.min_exposure, cfg.max_exposure);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_pixel && req_end_of_frame) begin
         fsum_ff <= fsum;
         adj_ff  <= recompute;
      end
      if (cmd.gep) begin
         gep_ff <= GEP_W'(gain_ff) * GEP_W'(exp_ff);
      end
      if (cmd.mul) begin
         num_ff <= {PROD_W'(gep_ff) * PROD_W'(cfg.target_sum), {FRAC_BITS{1'b0}}};
         rem_ff <= '0;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
         num_ff <= {num_ff[NUM_W-2:0], fits};
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.round_e1) begin
         e1_ff <= clamp_exp(rnd1, cfg.min_exposure, cfg.max_exposure);
      end
      if (cmd.pick_gain) begin
         priority if (num_ff <= unit1) lg_ff <= 2'd0;
         else if (num_ff <= unit2) lg_ff <= 2'd1;
         else if (num_ff <= unit4) lg_ff <= 2'd2;
         else lg_ff <= 2'd3;
      end
   end

   assign rsp_exposure_time = exp_ff;
   assign rsp_gain_factor   = gain_ff;
   assign rsp_converged     = lock_ff;
   assign rsp_adjusted      = adj_ff;
   assign rsp_luma_sum      = fsum_ff;

endmodule

### dv/frame_auto_exposure_core_test.sv
module frame_auto_exposure_core_test;

   // Fraction bits of the exposure arithmetic; the core is built with the same value.
   localparam int FRAC = 8;
   // The divider path is the slowest frame-end computation; add margin on top.
   localparam int SETTLE_CYCLES = FRAC + 54 + 8;
   // No transfer in this many cycles means the core hung.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct packed {
      logic [fae_pkg::EXP_W-1:0]  exposure_time;
      logic [fae_pkg::GAIN_W-1:0] gain_factor;
      logic                       converged;
      logic                       adjusted;
      logic [fae_pkg::SUM_W-1:0]  luma_sum;
   } frame_report_type;

   // Tracks exposure, gain and lock the way the core should, and holds the
   // frame reports that are still on their way.
   class exposure_scoreboard;
      fae_pkg::cfg_type           regs;
      logic [fae_pkg::SUM_W-1:0]  luma_acc;
      logic                       locked;
      logic [fae_pkg::EXP_W-1:0]  exposure;
      logic [fae_pkg::GAIN_W-1:0] gain;
      frame_report_type           awaited[$];
      int unsigned                pixels_seen;
      int unsigned                frames_seen;
      int unsigned                reports_checked;
      int unsigned                retunes;
      int unsigned                locked_frames;
      int unsigned                failures;

      function new();
         regs.ae_enable    = 1'b1;
         regs.target_sum   = fae_pkg::TARGET_SUM_RESET;
         regs.inner_low    = fae_pkg::INNER_LOW_RESET;
         regs.inner_high   = fae_pkg::INNER_HIGH_RESET;
         regs.outer_low    = fae_pkg::OUTER_LOW_RESET;
         regs.outer_high   = fae_pkg::OUTER_HIGH_RESET;
         regs.min_exposure = fae_pkg::MIN_EXPOSURE_RESET;
         regs.max_exposure = fae_pkg::MAX_EXPOSURE_RESET;
         luma_acc = '0;
         locked   = 1'b0;
         exposure = fae_pkg::EXPOSURE_RESET;
         gain     = fae_pkg::GAIN_RESET;
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      function void note_config(fae_pkg::csr_index_type idx,
                                logic [fae_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            fae_pkg::CSR_AE_ENABLE:    regs.ae_enable    = value[0];
            fae_pkg::CSR_TARGET_SUM:   regs.target_sum   = value[fae_pkg::SUM_W-1:0];
            fae_pkg::CSR_INNER_LOW:    regs.inner_low    = value[fae_pkg::SUM_W-1:0];
            fae_pkg::CSR_INNER_HIGH:   regs.inner_high   = value[fae_pkg::SUM_W-1:0];
            fae_pkg::CSR_OUTER_LOW:    regs.outer_low    = value[fae_pkg::SUM_W-1:0];
            fae_pkg::CSR_OUTER_HIGH:   regs.outer_high   = value[fae_pkg::SUM_W-1:0];
            fae_pkg::CSR_MIN_EXPOSURE: regs.min_exposure = value[fae_pkg::EXP_W-1:0];
            fae_pkg::CSR_MAX_EXPOSURE: regs.max_exposure = value[fae_pkg::EXP_W-1:0];
            default: ;
         endcase
      endfunction

      // Raise to the minimum first, then cap at the maximum: the maximum wins.
      function logic [fae_pkg::EXP_W-1:0] clamp_exposure(logic [63:0] v);
         if (v < regs.min_exposure) v = regs.min_exposure;
         if (v > regs.max_exposure) v = regs.max_exposure;
         return v[fae_pkg::EXP_W-1:0];
      endfunction

      // Divide by 2^sh, rounding halves up.
      function logic [63:0] round_shift(logic [63:0] t, int sh);
         return (t >> sh) + ((t >> (sh - 1)) & 64'd1);
      endfunction

      // Scale gain*exposure by target/luma, then split it into gain and exposure.
      function void retune(logic [fae_pkg::SUM_W-1:0] luma);
         logic [63:0] gep;
         logic [63:0] t;
         logic [63:0] step_unit;
         int lg;
         if (luma == '0) begin
            gain     = fae_pkg::GAIN_X8;
            exposure = regs.max_exposure;
            return;
         end
         gep = 64'(gain) * 64'(exposure);
         t = ((gep * 64'(regs.target_sum)) << FRAC) / 64'(luma);
         step_unit = 64'(clamp_exposure(round_shift(t, FRAC))) << FRAC;
         if (t <= step_unit) begin
            gain = fae_pkg::GAIN_X1;
            lg = 0;
         end else if (t <= 2 * step_unit) begin
            gain = fae_pkg::GAIN_X2;
            lg = 1;
         end else if (t <= 4 * step_unit) begin
            gain = fae_pkg::GAIN_X4;
            lg = 2;
         end else begin
            gain = fae_pkg::GAIN_X8;
            lg = 3;
         end
         exposure = clamp_exposure(round_shift(t, FRAC + lg));
      endfunction

      function void note_pixel(logic [fae_pkg::PIX_W-1:0] px, logic eof);
         logic [fae_pkg::SUM_W:0] total;
         frame_report_type rep;
         pixels_seen++;
         total = {1'b0, luma_acc} + px;
         if (total > fae_pkg::SUM_MAX) total = fae_pkg::SUM_MAX;
         if (!eof) begin
            luma_acc = total[fae_pkg::SUM_W-1:0];
            return;
         end
         luma_acc = '0;
         rep.adjusted = 1'b0;
         if (regs.ae_enable) begin
            // Hysteresis: lock inside the inner band, release outside the outer one.
            if (regs.inner_low <= total && total <= regs.inner_high)
               locked = 1'b1;
            else if (total > regs.outer_high || total < regs.outer_low)
               locked = 1'b0;
            if (!locked) begin
               retune(total[fae_pkg::SUM_W-1:0]);
               rep.adjusted = 1'b1;
               retunes++;
            end
         end
         if (locked) locked_frames++;
         rep.exposure_time = exposure;
         rep.gain_factor   = gain;
         rep.converged     = locked;
         rep.luma_sum      = total[fae_pkg::SUM_W-1:0];
         frames_seen++;
         awaited.push_back(rep);
      endfunction

      function string describe(frame_report_type r);
         return $sformatf("exp=%0d gain=%0d conv=%0b adj=%0b luma=%0d",
                          r.exposure_time, r.gain_factor, r.converged, r.adjusted,
                          r.luma_sum);
      endfunction

      function void check_report(frame_report_type got);
         frame_report_type want;
         reports_checked++;
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("ERROR: frame report with none outstanding: %s", describe(got));
            return;
         end
         want = awaited.pop_front();
         if (got.exposure_time !== want.exposure_time ||
             got.gain_factor !== want.gain_factor ||
             got.converged !== want.converged || got.adjusted !== want.adjusted ||
             got.luma_sum !== want.luma_sum) begin
            failures++;
            if (failures <= 10)
               $display("ERROR: frame report %0d: expected %s, got %s",
                        reports_checked, describe(want), describe(got));
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [fae_pkg::PIX_W-1:0]      req_pixel;
   logic                           req_end_of_frame;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [fae_pkg::EXP_W-1:0]      rsp_exposure_time;
   logic [fae_pkg::GAIN_W-1:0]     rsp_gain_factor;
   logic                           rsp_converged;
   logic                           rsp_adjusted;
   logic [fae_pkg::SUM_W-1:0]      rsp_luma_sum;
   logic                           csr_wr_en;
   logic [fae_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [fae_pkg::CSR_DATA_W-1:0] csr_wdata;

   exposure_scoreboard tracker = new();

   // Random idling on both sides; cleared for the last stretch of the run.
   bit          idle_on = 1'b1;
   // Set by the stimulus to make the receiver hold off for that many cycles.
   int unsigned rsp_hold_request = 0;
   int unsigned long_holds = 0;
   int unsigned settings_applied = 0;
   int unsigned quiet_cycles = 0;

   frame_auto_exposure_core #(
      .FRAC_BITS(FRAC)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel         (req_pixel),
      .req_end_of_frame  (req_end_of_frame),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_exposure_time (rsp_exposure_time),
      .rsp_gain_factor   (rsp_gain_factor),
      .rsp_converged     (rsp_converged),
      .rsp_adjusted      (rsp_adjusted),
      .rsp_luma_sum      (rsp_luma_sum),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Sample both channels at the edge. Check the response first: it can never
   // belong to an end-of-frame pixel taken in the same cycle.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            tracker.check_report({rsp_exposure_time, rsp_gain_factor, rsp_converged,
                                  rsp_adjusted, rsp_luma_sum});
         if (req_valid && req_ready)
            tracker.note_pixel(req_pixel, req_end_of_frame);
      end
   end

   // Watchdog: count cycles without any transfer and abort the run on a hang.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver: stretches of readiness, random stall bursts, and one long hold-off
   // on request so the core backs up and stops taking pixels.
   initial begin
      int unsigned span;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_request != 0) begin
            span = rsp_hold_request;
            rsp_hold_request = 0;
            long_holds++;
            rsp_ready <= 1'b0;
            repeat (span) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Drop valid and let the given number of cycles pass.
   task automatic pause_sender(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Offer one pixel and hold it until the transfer happens.
   task automatic send_pixel(input logic [fae_pkg::PIX_W-1:0] px, input logic eof);
      if (idle_on && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 19));
      req_valid        <= 1'b1;
      req_pixel        <= px;
      req_end_of_frame <= eof;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_flat_frame(input int unsigned len,
                                  input logic [fae_pkg::PIX_W-1:0] level);
      for (int unsigned i = 0; i < len; i++) send_pixel(level, i == len - 1);
   endtask

   // Mostly frames of the nominal length with pixels near the mean, so the
   // sums land around the lock bands; some dark frames and some noise.
   task automatic send_random_frames(input int unsigned budget, input int unsigned nominal_len,
                                     input int unsigned mean_px);
      int unsigned sent;
      int unsigned len;
      int unsigned style;
      int level;
      sent = 0;
      while (sent < budget) begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : nominal_len;
         style = $urandom_range(0, 9);
         for (int unsigned i = 0; i < len; i++) begin
            case (style)
               0: level = 0;
               1, 2: level = $urandom_range(0, 255);
               default: level = int'(mean_px) + int'($urandom_range(0, 48)) - 24;
            endcase
            if (level < 0) level = 0;
            if (level > 255) level = 255;
            send_pixel(level[fae_pkg::PIX_W-1:0], i == len - 1);
         end
         sent += len;
      end
   endtask

   // Drain every outstanding frame report, then give the core time to settle.
   task automatic wait_idle();
      pause_sender(1);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic fae_pkg::cfg_type make_settings(
      input logic ae, input int unsigned target, input int unsigned il, input int unsigned ih,
      input int unsigned ol, input int unsigned oh, input int unsigned mn, input int unsigned mx);
      fae_pkg::cfg_type s;
      s.ae_enable    = ae;
      s.target_sum   = target[fae_pkg::SUM_W-1:0];
      s.inner_low    = il[fae_pkg::SUM_W-1:0];
      s.inner_high   = ih[fae_pkg::SUM_W-1:0];
      s.outer_low    = ol[fae_pkg::SUM_W-1:0];
      s.outer_high   = oh[fae_pkg::SUM_W-1:0];
      s.min_exposure = mn[fae_pkg::EXP_W-1:0];
      s.max_exposure = mx[fae_pkg::EXP_W-1:0];
      return s;
   endfunction

   // Bands centered on the target; occasionally AE off or the minimum above the maximum.
   function automatic fae_pkg::cfg_type random_settings(input int unsigned target);
      int unsigned d_in;
      int unsigned d_out;
      int unsigned mn;
      int unsigned mx;
      d_in  = $urandom_range(0, target / 8);
      d_out = $urandom_range(0, target / 4);
      mn = $urandom_range(1, 3000);
      mx = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3000) : $urandom_range(3000, 1048575);
      return make_settings($urandom_range(0, 5) != 0, target, target - d_in, target + d_in,
                           (target > d_in + d_out) ? target - d_in - d_out : 0,
                           target + d_in + d_out, mn, mx);
   endfunction

   // Write every register while the core is idle, in index order.
   task automatic apply_settings(input fae_pkg::cfg_type s);
      logic [fae_pkg::CSR_DATA_W-1:0] value;
      fae_pkg::csr_index_type idx;
      wait_idle();
      idx = idx.first();
      repeat (idx.num()) begin
         case (idx)
            fae_pkg::CSR_AE_ENABLE:    value = fae_pkg::CSR_DATA_W'(s.ae_enable);
            fae_pkg::CSR_TARGET_SUM:   value = s.target_sum;
            fae_pkg::CSR_INNER_LOW:    value = s.inner_low;
            fae_pkg::CSR_INNER_HIGH:   value = s.inner_high;
            fae_pkg::CSR_OUTER_LOW:    value = s.outer_low;
            fae_pkg::CSR_OUTER_HIGH:   value = s.outer_high;
            fae_pkg::CSR_MIN_EXPOSURE: value = fae_pkg::CSR_DATA_W'(s.min_exposure);
            fae_pkg::CSR_MAX_EXPOSURE: value = fae_pkg::CSR_DATA_W'(s.max_exposure);
            default:                   value = '0;
         endcase
         csr_wr_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value;
         tracker.note_config(idx, value);
         @(posedge clock);
         idx = idx.next();
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
      settings_applied++;
   endtask

   initial begin : stimulus
      int unsigned nominal;
      int unsigned mean;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_pixel        <= '0;
      req_end_of_frame <= 1'b0;
      csr_wr_en        <= 1'b0;
      csr_index        <= fae_pkg::CSR_AE_ENABLE;
      csr_wdata        <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: dark frame, then tiny frames far below the target.
      send_flat_frame(1, 8'd0);
      send_flat_frame(2, 8'd255);
      send_flat_frame(3, 8'd128);

      // Narrow bands around a two-pixel frame: lock, hold inside the hysteresis
      // gap, release above the outer band, retune while unlocked, dark frame.
      apply_settings(make_settings(1'b1, 256, 240, 272, 224, 288, 20, 19140));
      send_flat_frame(2, 8'd128);
      send_flat_frame(2, 8'd115);
      send_flat_frame(2, 8'd200);
      send_flat_frame(2, 8'd115);
      send_flat_frame(2, 8'd0);
      send_flat_frame(1, 8'd1);
      send_flat_frame(1, 8'd255);

      // AE off: lock, gain and exposure stay put, adjusted stays low.
      apply_settings(make_settings(1'b0, 256, 240, 272, 224, 288, 20, 19140));
      send_flat_frame(2, 8'd128);
      send_flat_frame(1, 8'd255);
      send_flat_frame(2, 8'd0);

      // Minimum above maximum: the maximum wins the clamp.
      apply_settings(make_settings(1'b1, 256, 240, 272, 224, 288, 20'hFFFFF, 1));
      send_flat_frame(1, 8'd77);
      send_flat_frame(2, 8'd200);

      // Exposure range [0,1] with target 1: drive the first exposure estimate to
      // zero, once with a nonzero scaled target (gain 8) and once with zero (gain 1).
      apply_settings(make_settings(1'b1, 1, fae_pkg::SUM_MAX, fae_pkg::SUM_MAX,
                                   0, 0, 0, 1));
      send_flat_frame(1, 8'd255);
      send_flat_frame(1, 8'd255);
      send_flat_frame(1, 8'd255);

      // Full-scale registers: widest products and quotients through the divider.
      apply_settings(make_settings(1'b1, fae_pkg::SUM_MAX, fae_pkg::SUM_MAX - 1000,
                                   fae_pkg::SUM_MAX, 0, fae_pkg::SUM_MAX, 1, 20'hFFFFF));
      send_flat_frame(1, 8'd255);
      send_flat_frame(1, 8'd255);
      send_flat_frame(1, 8'd0);

      // Random phases; the third holds the receiver off for a long stretch,
      // the last one runs without any idling.
      for (int ph = 0; ph < 5; ph++) begin
         nominal = $urandom_range(1, 4);
         mean    = $urandom_range(16, 240);
         apply_settings(random_settings(nominal * mean));
         if (ph == 2) rsp_hold_request = LONG_HOLD_CYCLES;
         if (ph == 4) idle_on = 1'b0;
         send_random_frames(84, nominal, mean);
      end

      wait_idle();
      $display("Run covered %0d pixels in %0d frames under %0d register settings",
               tracker.pixels_seen, tracker.frames_seen, settings_applied);
      $display("%0d retunes, %0d locked frames, %0d long receiver hold-offs, %0d mismatches",
               tracker.retunes, tracker.locked_frames, long_holds, tracker.failures);
      if (tracker.failures == 0 && tracker.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
